>>> hw/rtl/six_channel_sample_averager_top_defines.svh
// Assertion macros used by the averager's top-level RTL file.
`ifndef SIX_CHANNEL_SAMPLE_AVERAGER_TOP_DEFINES_SVH
`define SIX_CHANNEL_SAMPLE_AVERAGER_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SCSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SCSA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/scsa_pkg.sv
package scsa_pkg;

    localparam int NUM_CHAN     = 6;
    localparam int SAMPLE_BITS  = 16;
    localparam int SAMPLE_W     = 16;
    localparam int AVG_W        = 16;
    localparam int COUNT_MAX    = 1023;
    localparam int CNT_W        = $clog2(COUNT_MAX + 1);
    localparam int THR_W        = 10;
    localparam int CMP_W        = (CNT_W > THR_W) ? CNT_W : THR_W;
    // Sums must hold COUNT_MAX full-scale samples of either sign.
    localparam int SUM_W        = $clog2(COUNT_MAX) + SAMPLE_BITS + 1;
    localparam int CH_W         = $clog2(NUM_CHAN);
    localparam int STEP_W       = $clog2(SUM_W);
    localparam int IN_TDATA_W   = ((NUM_CHAN * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((NUM_CHAN * AVG_W + CNT_W + 7) / 8) * 8;
    localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(100);

    typedef struct packed {
        logic            accept;
        logic            load_div;
        logic            step_div;
        logic            store_q;
        logic            load_out;
        logic [CH_W-1:0] chan;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic out_free;
    } t_stat;

endpackage

>>> hw/rtl/scsa_ctrl.sv
module scsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  scsa_pkg::t_stat  i_stat,
    output scsa_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ITER  = 3'd2;
    localparam logic [2:0] ST_STORE = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [scsa_pkg::STEP_W-1:0] LAST_STEP =
        scsa_pkg::STEP_W'(scsa_pkg::SUM_W - 1);
    localparam logic [scsa_pkg::CH_W-1:0] LAST_CHAN =
        scsa_pkg::CH_W'(scsa_pkg::NUM_CHAN - 1);

    logic [2:0]                    r_state, n_state;
    logic [scsa_pkg::CH_W-1:0]     r_chan, n_chan;
    logic [scsa_pkg::STEP_W-1:0]   r_step, n_step;
    logic                          w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        n_chan         = r_chan;
        n_step         = r_step;
        o_cmd          = '0;
        o_cmd.accept   = w_accept;
        o_cmd.chan     = r_chan;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_stat.emit) begin
                    n_state = ST_LOAD;
                    n_chan  = '0;
                end
            end
            ST_LOAD: begin
                o_cmd.load_div = 1'b1;
                n_step         = '0;
                n_state        = ST_ITER;
            end
            ST_ITER: begin
                o_cmd.step_div = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                o_cmd.store_q = 1'b1;
                if (r_chan == LAST_CHAN) begin
                    n_state = ST_OUT;
                end else begin
                    n_chan  = r_chan + 1'b1;
                    n_state = ST_LOAD;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_chan  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
            r_step  <= n_step;
        end
    end

endmodule

>>> hw/rtl/scsa_dp.sv
module scsa_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  scsa_pkg::t_cmd                      i_cmd,
    output scsa_pkg::t_stat                     o_stat,
    input  logic                                i_cfg_we,
    input  logic [scsa_pkg::THR_W-1:0]          i_cfg_data,
    // Fields from bit 0 up: x/y/z rate sample, x/y/z accel sample.
    input  logic [scsa_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  logic                                i_in_restart,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    // Fields from bit 0 up: x/y/z rate avg, x/y/z accel avg, scans averaged.
    output logic [scsa_pkg::OUT_TDATA_W-1:0]    o_out_data,
    output logic                                o_out_ovf
);

    localparam int SUM_W = scsa_pkg::SUM_W;
    localparam int CNT_W = scsa_pkg::CNT_W;
    localparam int AVG_W = scsa_pkg::AVG_W;
    localparam int NCH   = scsa_pkg::NUM_CHAN;
    localparam int SB    = scsa_pkg::SAMPLE_BITS;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(scsa_pkg::COUNT_MAX);

    logic signed [SUM_W-1:0] r_sum [NCH];
    logic signed [SUM_W-1:0] n_sum [NCH];
    logic [CNT_W-1:0]        r_count, n_count, w_base_cnt;
    logic                    r_drop, n_drop, w_full;
    logic [scsa_pkg::THR_W-1:0] r_thresh;

    logic [CNT_W-1:0]        r_rem, n_rem;
    logic [SUM_W-1:0]        r_quo;
    logic                    r_neg;
    logic [CNT_W:0]          w_shift;
    logic                    w_ge;
    logic signed [SUM_W-1:0] w_sel_sum;
    logic [SUM_W-1:0]        w_mag;
    logic [AVG_W-1:0]        w_q16;

    logic [AVG_W-1:0]        r_avg [NCH];
    logic [AVG_W-1:0]        r_out_avg [NCH];
    logic [CNT_W-1:0]        r_out_cnt;
    logic                    r_out_ovf;
    logic                    r_out_valid;

    // Scan update: optional restart, then add unless the count is saturated.
    always_comb begin
        logic signed [SUM_W-1:0] base;
        logic signed [SUM_W-1:0] smp;
        w_base_cnt = i_in_restart ? '0 : r_count;
        w_full     = (w_base_cnt >= CNT_FULL);
        n_count    = w_full ? w_base_cnt : w_base_cnt + 1'b1;
        n_drop     = (i_in_restart ? 1'b0 : r_drop) | w_full;
        for (int i = 0; i < NCH; i++) begin
            base = i_in_restart ? '0 : r_sum[i];
            smp  = SUM_W'($signed(i_in_data[i*scsa_pkg::SAMPLE_W +: SB]));
            n_sum[i] = w_full ? base : base + smp;
        end
    end

    assign o_stat.emit     = (scsa_pkg::CMP_W'(n_count) > scsa_pkg::CMP_W'(r_thresh));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Restoring divider: one quotient bit per step on the sum magnitude.
    assign w_sel_sum = r_sum[i_cmd.chan];
    assign w_mag     = w_sel_sum[SUM_W-1] ? SUM_W'(-w_sel_sum) : SUM_W'(w_sel_sum);
    assign w_shift   = {r_rem, r_quo[SUM_W-1]};
    assign w_ge      = (w_shift >= {1'b0, r_count});
    assign n_rem     = w_ge ? CNT_W'(w_shift - {1'b0, r_count}) : w_shift[CNT_W-1:0];
    assign w_q16     = r_neg ? AVG_W'(-r_quo[AVG_W-1:0]) : r_quo[AVG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                r_sum[i] <= '0;
            end
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_thresh    <= scsa_pkg::THRESH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                for (int i = 0; i < NCH; i++) begin
                    r_sum[i] <= n_sum[i];
                end
                r_count <= n_count;
                r_drop  <= n_drop;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_rem <= '0;
            r_quo <= w_mag;
            r_neg <= w_sel_sum[SUM_W-1];
        end else if (i_cmd.step_div) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
        end
        if (i_cmd.store_q) begin
            r_avg[i_cmd.chan] <= w_q16;
        end
        if (i_cmd.load_out) begin
            for (int i = 0; i < NCH; i++) begin
                r_out_avg[i] <= r_avg[i];
            end
            r_out_cnt <= r_count;
            r_out_ovf <= r_drop;
        end
    end

    always_comb begin
        o_out_data = '0;
        for (int i = 0; i < NCH; i++) begin
            o_out_data[i*AVG_W +: AVG_W] = r_out_avg[i];
        end
        o_out_data[NCH*AVG_W +: CNT_W] = r_out_cnt;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_ovf   = r_out_ovf;

endmodule

>>> hw/rtl/six_channel_sample_averager_top.sv
// Six-channel boxcar averager for converter scans.
// The slave stream takes one scan per request: tdata carries the x, y, z rate
// samples and then the x, y, z accelerometer samples, 16 bits each, and tuser
// carries the restart flag, which clears the sums, count and drop flag first.
// Each accepted scan is added to six running sums in the cycle it is taken,
// unless the count has saturated. When the scan count then exceeds the
// threshold register, the six averages are formed by one shared restoring
// divider that produces one quotient bit per cycle, with a load, 27 quotient
// steps and a store per channel; the result is then offered on the master
// stream once the output register is free. The slave side opens again after
// that, so no new scan is taken while a result is being formed, while a scan
// that produces none leaves it ready; throughput is set by that divider loop.
// The master tdata carries the six averages and the scan count; tuser is the
// overflow flag. A result sits in an output register, so a stalled receiver
// only holds back the next scan that would also produce a result.
// The threshold is written through the cfg channel, which is always ready.
// Synchronous active-low reset clears the sums, count, drop flag and handshake
// state and returns the threshold to 100.
`include "six_channel_sample_averager_top_defines.svh"

module six_channel_sample_averager_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // Fields from bit 0 up: x_rate, y_rate, z_rate, x_accel, y_accel, z_accel.
    input  logic [scsa_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // Fields from bit 0 up: restart.
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // Fields from bit 0 up: x_rate_avg, y_rate_avg, z_rate_avg, x_accel_avg,
    // y_accel_avg, z_accel_avg, scans_averaged, zero padding.
    output logic [scsa_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // Fields from bit 0 up: overflowed.
    output logic                                o_m_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [scsa_pkg::THR_W-1:0]          i_cfg_data
);

    scsa_pkg::t_cmd  w_cmd;
    scsa_pkg::t_stat w_stat;

    // Signals used only by the checks at the end of the module.
    logic                       w_emit_take;
    logic [scsa_pkg::CNT_W-1:0] w_out_cnt;
    logic                       w_out_full;

    // Register writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;

    scsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    scsa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_data    (i_s_tdata),
        .i_in_restart (i_s_tuser),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_out_data   (o_m_tdata),
        .o_out_ovf    (o_m_tuser)
    );

    // A scan request taken at this edge that will produce a result.
    assign w_emit_take = i_s_tvalid && o_s_tready && w_stat.emit;
    // The scans_averaged field of the presented result.
    assign w_out_cnt   = o_m_tdata[scsa_pkg::NUM_CHAN*scsa_pkg::AVG_W +: scsa_pkg::CNT_W];
    assign w_out_full  = (w_out_cnt == scsa_pkg::CNT_W'(scsa_pkg::COUNT_MAX));

    // A scan that produces a result must close the slave side while dividing.
    `SCSA_ASSERT_NXT(a_busy_after_emit, w_emit_take, !o_s_tready, "slave side open during division")
    // A delivered result always covers at least one scan.
    `SCSA_ASSERT_IMP(a_count_nonzero, o_m_tvalid, w_out_cnt != '0, "result with zero scans")
    // Dropped scans happen only once the count has saturated.
    `SCSA_ASSERT_IMP(a_ovf_saturated, o_m_tvalid && o_m_tuser, w_out_full, "overflow early")

endmodule
